FILE: hw/rtl/bpmc_pkg.sv
// Package: shared types and codes for the button power-mode controller.
package bpmc_pkg;

    // Device states (3-bit field; codes 5 to 7 can be loaded and are kept)
    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_HEATING  = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_ON       = 3'd3;
    localparam logic [2:0] ST_OVERTEMP = 3'd4;

    // LED colour codes
    localparam logic [1:0] COL_OFF   = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_GREEN = 2'd2;
    localparam logic [1:0] COL_UNSET = 2'd3;

    // Power enable bit positions
    localparam int EN_LASER_HI = 0;
    localparam int EN_LASER_LO = 1;
    localparam int EN_HEATER   = 2;
    localparam int EN_COOLER   = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [1:0] CFG_CLICK_MIN  = 2'd1;
    localparam logic [1:0] CFG_CLICK_GAP  = 2'd2;

    localparam logic [11:0] LONG_PRESS_RESET = 12'd1000;
    localparam logic [7:0]  CLICK_MIN_RESET  = 8'd3;
    localparam logic [7:0]  CLICK_GAP_RESET  = 8'd5;
    localparam logic [3:0]  FLASH_RESET      = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HALT1  = 3'd1,
        PH_HALT2  = 3'd2,
        PH_CLICK1 = 3'd4,
        PH_CLICK2 = 3'd5
    } phase_t;

    typedef struct packed {
        logic       switch_released;
        logic       blink_tick;
        logic       state_write;
        logic [2:0] state_value;
    } bpmc_in_t;

    typedef struct packed {
        logic [2:0] device_mode;
        logic       laser_high_enable;
        logic       laser_low_enable;
        logic       heater_enable;
        logic       cooler_enable;
        logic       led_red;
        logic       led_grn;
        logic       expander_write;
        logic       short_click;
        logic       long_press;
        logic       double_click;
    } bpmc_out_t;

    typedef struct packed {
        logic [11:0] long_press_ticks;
        logic [7:0]  click_min_ticks;
        logic [7:0]  click_gap_ticks;
    } bpmc_cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [11:0] counter;
        logic [2:0]  dev;
        logic [3:0]  enables;
        logic [3:0]  flash;
        logic [1:0]  colour;
    } bpmc_state_t;

endpackage

FILE: hw/rtl/button_power_mode_controller.sv
// Top level: button power-mode controller with input and result registers.
//
// One item per clock is accepted unless the output is stalled, and one result
// item is returned for each. An item is captured in the input register,
// processed in one pass of the step logic (button classifier, long-press mode
// stepping, LED blink) and written to the result register once that register
// is empty or its item is taken; while the output is stalled the item waits in
// the input register. The device state and press counter update when an
// item moves into the result register, which is what limits the rate to one
// item per cycle. Configuration registers may be written only while no item
// is in flight; the write port is always ready, and writes to index 3 are
// ignored.
module button_power_mode_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpmc_pkg::bpmc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpmc_pkg::bpmc_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    logic                  in_valid_reg;
    bpmc_pkg::bpmc_in_t    in_data_reg;
    logic                  out_valid_reg;
    bpmc_pkg::bpmc_out_t   out_data_reg;
    bpmc_pkg::bpmc_cfg_t   cfg_reg;
    bpmc_pkg::bpmc_state_t state_reg;
    bpmc_pkg::bpmc_state_t state_next;
    bpmc_pkg::bpmc_out_t   result;
    logic                  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    bpmc_step u_step (
        .cur  (state_reg),
        .item (in_data_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= bpmc_pkg::PH_IDLE;
            state_reg.counter <= bpmc_pkg::LONG_PRESS_RESET;
            state_reg.dev     <= bpmc_pkg::ST_OFF;
            state_reg.enables <= 4'd0;
            state_reg.flash   <= bpmc_pkg::FLASH_RESET;
            state_reg.colour  <= bpmc_pkg::COL_UNSET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks <= bpmc_pkg::LONG_PRESS_RESET;
            cfg_reg.click_min_ticks  <= bpmc_pkg::CLICK_MIN_RESET;
            cfg_reg.click_gap_ticks  <= bpmc_pkg::CLICK_GAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bpmc_pkg::CFG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                bpmc_pkg::CFG_CLICK_MIN:  cfg_reg.click_min_ticks  <= cfg_data[7:0];
                bpmc_pkg::CFG_CLICK_GAP:  cfg_reg.click_gap_ticks  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/bpmc_step.sv
// Next-state and result logic for one tick of the controller.
module bpmc_step (
    input  bpmc_pkg::bpmc_state_t cur,
    input  bpmc_pkg::bpmc_in_t    item,
    input  bpmc_pkg::bpmc_cfg_t   cfg,
    output bpmc_pkg::bpmc_state_t nxt,
    output bpmc_pkg::bpmc_out_t   res
);

    logic [12:0] min_sum;
    logic [12:0] gap_sum;
    logic        below_min;
    logic        below_gap;
    logic [11:0] cnt_dec;
    logic        wrote;
    logic        ev_short;
    logic        ev_long;
    logic        ev_double;
    logic        col_req;
    logic [1:0]  col_val;

    // counter < ticks - margin, rewritten to avoid a signed threshold
    assign min_sum   = {1'b0, cur.counter} + {5'd0, cfg.click_min_ticks};
    assign gap_sum   = {1'b0, cur.counter} + {5'd0, cfg.click_gap_ticks};
    assign below_min = min_sum < {1'b0, cfg.long_press_ticks};
    assign below_gap = gap_sum < {1'b0, cfg.long_press_ticks};
    // hold at zero instead of wrapping
    assign cnt_dec   = (cur.counter != 12'd0) ? cur.counter - 12'd1 : cur.counter;

    always_comb begin
        nxt       = cur;
        wrote     = 1'b0;
        ev_short  = 1'b0;
        ev_long   = 1'b0;
        ev_double = 1'b0;
        col_req   = 1'b0;
        col_val   = bpmc_pkg::COL_OFF;

        if (item.state_write) begin
            nxt.dev = item.state_value;
        end

        case (cur.phase)
            bpmc_pkg::PH_IDLE: begin
                if (item.switch_released) begin
                    if (below_min) begin
                        nxt.phase = bpmc_pkg::PH_CLICK1;
                    end
                    nxt.counter = cfg.long_press_ticks;
                end else if (cur.counter == 12'd0) begin
                    nxt.phase = bpmc_pkg::PH_HALT1;
                    ev_long   = 1'b1;
                    wrote     = 1'b1;
                    case (nxt.dev)
                        bpmc_pkg::ST_OFF, bpmc_pkg::ST_OVERTEMP: begin
                            nxt.dev = bpmc_pkg::ST_HEATING;
                            nxt.enables[bpmc_pkg::EN_COOLER] = 1'b1;
                        end
                        bpmc_pkg::ST_HEATING: begin
                            nxt.dev = bpmc_pkg::ST_OFF;
                            nxt.enables[bpmc_pkg::EN_COOLER] = 1'b0;
                        end
                        bpmc_pkg::ST_READY: begin
                            nxt.dev = bpmc_pkg::ST_ON;
                            nxt.enables[bpmc_pkg::EN_LASER_HI] = 1'b1;
                            nxt.enables[bpmc_pkg::EN_LASER_LO] = 1'b1;
                            nxt.enables[bpmc_pkg::EN_HEATER]   = 1'b1;
                        end
                        bpmc_pkg::ST_ON: begin
                            nxt.dev     = bpmc_pkg::ST_OFF;
                            nxt.enables = 4'd0;
                        end
                        default: begin
                            nxt.dev = bpmc_pkg::ST_OFF;
                        end
                    endcase
                end else begin
                    nxt.counter = cnt_dec;
                end
            end
            bpmc_pkg::PH_CLICK1: begin
                if (item.switch_released) begin
                    nxt.counter = cnt_dec;
                    if (below_gap) begin
                        ev_short    = 1'b1;
                        wrote       = 1'b1;
                        nxt.dev     = bpmc_pkg::ST_OFF;
                        nxt.enables = 4'd0;
                        nxt.phase   = bpmc_pkg::PH_IDLE;
                        nxt.counter = cfg.long_press_ticks;
                    end
                end else begin
                    ev_double   = 1'b1;
                    nxt.phase   = bpmc_pkg::PH_CLICK2;
                    nxt.counter = cfg.long_press_ticks;
                end
            end
            bpmc_pkg::PH_CLICK2: begin
                if (item.switch_released) begin
                    nxt.phase   = bpmc_pkg::PH_IDLE;
                    nxt.counter = cfg.long_press_ticks;
                end
            end
            bpmc_pkg::PH_HALT1: begin
                if (item.switch_released) begin
                    nxt.phase = bpmc_pkg::PH_HALT2;
                end
            end
            bpmc_pkg::PH_HALT2: begin
                nxt.phase   = bpmc_pkg::PH_IDLE;
                nxt.counter = cfg.long_press_ticks;
            end
            default: begin
                nxt.phase = bpmc_pkg::PH_IDLE;
            end
        endcase

        if (item.blink_tick) begin
            case (nxt.dev)
                bpmc_pkg::ST_OVERTEMP: begin
                    col_req = 1'b1;
                    if (cur.flash > 4'd3) begin
                        col_val   = bpmc_pkg::COL_RED;
                        nxt.flash = 4'd0;
                    end else begin
                        col_val   = bpmc_pkg::COL_OFF;
                        nxt.flash = cur.flash + 4'd1;
                    end
                end
                bpmc_pkg::ST_OFF: begin
                    if (cur.flash > 4'd4) begin
                        col_req   = 1'b1;
                        col_val   = bpmc_pkg::COL_RED;
                        nxt.flash = 4'd0;
                    end else begin
                        nxt.flash = cur.flash + 4'd1;
                    end
                end
                bpmc_pkg::ST_HEATING: begin
                    col_req = 1'b1;
                    if (cur.flash > 4'd3) begin
                        col_val   = bpmc_pkg::COL_GREEN;
                        nxt.flash = 4'd0;
                    end else begin
                        col_val   = bpmc_pkg::COL_RED;
                        nxt.flash = cur.flash + 4'd1;
                    end
                end
                bpmc_pkg::ST_READY: begin
                    col_req = 1'b1;
                    if (cur.flash > 4'd3) begin
                        col_val   = bpmc_pkg::COL_OFF;
                        nxt.flash = 4'd0;
                    end else begin
                        col_val   = bpmc_pkg::COL_GREEN;
                        nxt.flash = cur.flash + 4'd1;
                    end
                end
                bpmc_pkg::ST_ON: begin
                    col_req = 1'b1;
                    col_val = bpmc_pkg::COL_GREEN;
                end
                default: begin
                    col_req = 1'b0;
                end
            endcase
        end

        // a colour change also marks an expander write
        if (col_req && (col_val != cur.colour)) begin
            nxt.colour = col_val;
            wrote      = 1'b1;
        end
    end

    always_comb begin
        res.device_mode       = nxt.dev;
        res.laser_high_enable = nxt.enables[bpmc_pkg::EN_LASER_HI];
        res.laser_low_enable  = nxt.enables[bpmc_pkg::EN_LASER_LO];
        res.heater_enable     = nxt.enables[bpmc_pkg::EN_HEATER];
        res.cooler_enable     = nxt.enables[bpmc_pkg::EN_COOLER];
        res.led_red           = (nxt.colour == bpmc_pkg::COL_RED);
        res.led_grn           = (nxt.colour == bpmc_pkg::COL_GREEN);
        res.expander_write    = wrote;
        res.short_click       = ev_short;
        res.long_press        = ev_long;
        res.double_click      = ev_double;
    end

endmodule

FILE: hw/rtl/bpmc_checker.sv
// Port-level checker for the button power-mode controller, with its bind.
module bpmc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bpmc_pkg::bpmc_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_data.short_click, m_data.long_press, m_data.double_click}))
        else $error("more than one button event in one item");

    a_click_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.short_click |-> m_data.device_mode == bpmc_pkg::ST_OFF
            && !m_data.laser_high_enable && !m_data.laser_low_enable
            && !m_data.heater_enable && !m_data.cooler_enable && m_data.expander_write)
        else $error("short click did not force off");

    a_long_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.long_press |-> m_data.expander_write
            && (m_data.device_mode == bpmc_pkg::ST_OFF
                || m_data.device_mode == bpmc_pkg::ST_HEATING
                || m_data.device_mode == bpmc_pkg::ST_ON))
        else $error("long press result inconsistent");

endmodule

bind button_power_mode_controller bpmc_checker u_bpmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
